FILE: sv/mexp_pkg.sv
package mexp_pkg;

	localparam int MOD_W = 31;
	localparam int OPD_W = 32;
	localparam int MM_CNT_W = $clog2(OPD_W + 1);

	localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RED  = 4'b0010,
		S_MUL  = 4'b0100,
		S_FIN  = 4'b1000
	} mexp_state_t;

	typedef struct packed {
		logic start;
		logic done;
	} mm_ctl_t;

endpackage

FILE: sv/mexp_if.sv
interface mexp_cmd_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [mexp_pkg::OPD_W-1:0] base;
	logic [mexp_pkg::OPD_W-1:0] exponent;

	modport source (output valid, output op, output base, output exponent, input ready);
	modport sink (input valid, input op, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [mexp_pkg::MOD_W-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

interface mexp_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mexp_pkg::MOD_W-1:0] modulus;

	modport source (output valid, output modulus, input ready);
	modport sink (input valid, input modulus, output ready);
endinterface

FILE: sv/modular_exponentiation_core.sv
// Flow: base reduction, then one square and one multiply per exponent bit, side by side
// in two bit-serial modular multipliers; a modulus below 2 goes straight to the result,
// and the inverse of a base that reduces to zero ends after the base reduction.
// Requests: one at a time; a new request is taken only once the last result has been
// loaded into the response register, so a stalled response also holds off new requests.
// Reset: asynchronous, active low; modulus returns to 1000000007, no request pending.
module modular_exponentiation_core #(
	parameter int EXP_BITS = 32
) (
	input logic      clk,
	input logic      arst_n,
	mexp_cfg_if.sink cfg,
	mexp_cmd_if.sink cmd,
	mexp_rsp_if.source rsp
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(EXP_BITS + 1);

	mexp_state_t         state_q;
	logic [MOD_W-1:0]    mod_q;
	logic [MOD_W-1:0]    acc_q;
	logic [MOD_W-1:0]    sq_q;
	logic [EXP_BITS-1:0] e_q;
	logic                op_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                go_q;
	logic                rsp_valid_q;
	logic [MOD_W-1:0]    res_q;

	mm_ctl_t          mm0;
	mm_ctl_t          mm1;
	logic [MOD_W-1:0] mm0_a;
	logic [OPD_W-1:0] mm0_b;
	logic [MOD_W-1:0] p0;
	logic [MOD_W-1:0] p1;

	logic        cmd_acc;
	logic        mod_ok;
	logic [63:0] exp_ext;
	logic [63:0] inv_ext;
	logic        out_free;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign mod_ok    = (mod_q > MOD_W'(1));
	assign exp_ext   = {32'b0, cmd.exponent};
	assign inv_ext   = {33'b0, mod_q - MOD_W'(2)};
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign mm0.start = (cmd_acc && mod_ok) || go_q;
	assign mm1.start = go_q;
	assign mm0_a     = (state_q == S_IDLE) ? MOD_W'(1) : acc_q;
	assign mm0_b     = (state_q == S_IDLE) ? cmd.base : {1'b0, sq_q};

	mexp_mulmod u_mm0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm0.start),
		.a      (mm0_a),
		.b      (mm0_b),
		.m      (mod_q),
		.done   (mm0.done),
		.p      (p0)
	);

	mexp_mulmod u_mm1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm1.start),
		.a      (sq_q),
		.b      ({1'b0, sq_q}),
		.m      (mod_q),
		.done   (mm1.done),
		.p      (p1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mod_q       <= MOD_RESET;
			go_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			go_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				mod_q <= cfg.modulus;
			end
			if ((state_q == S_FIN) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						state_q <= mod_ok ? S_RED : S_FIN;
					end
				end
				S_RED: begin
					if (mm0.done) begin
						cnt_q <= CNT_W'(EXP_BITS);
						if (op_q && (p0 == '0)) begin
							state_q <= S_FIN;
						end else begin
							go_q    <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (mm1.done) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							state_q <= S_FIN;
						end else begin
							go_q <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					op_q  <= cmd.op;
					e_q   <= exp_ext[EXP_BITS-1:0];
					acc_q <= '0;
				end
			end
			S_RED: begin
				if (mm0.done) begin
					sq_q  <= p0;
					acc_q <= (op_q && (p0 == '0)) ? '0 : MOD_W'(1);
					if (op_q) begin
						e_q <= inv_ext[EXP_BITS-1:0];
					end
				end
			end
			S_MUL: begin
				if (mm1.done) begin
					if (e_q[0]) begin
						acc_q <= p0;
					end
					sq_q <= p1;
					e_q  <= e_q >> 1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					res_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = res_q;

endmodule

FILE: sv/mexp_mulmod.sv
module mexp_mulmod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mexp_pkg::MOD_W-1:0] a,
	input  logic [mexp_pkg::OPD_W-1:0] b,
	input  logic [mexp_pkg::MOD_W-1:0] m,
	output logic                       done,
	output logic [mexp_pkg::MOD_W-1:0] p
);
	import mexp_pkg::*;

	// a * b mod m, one bit of b per cycle from the MSB; requires a < m
	logic [MOD_W-1:0]    acc_q;
	logic [MOD_W-1:0]    a_q;
	logic [OPD_W-1:0]    b_q;
	logic [MM_CNT_W-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [MOD_W+2:0] t;
	logic [MOD_W+2:0] d1;
	logic [MOD_W+2:0] d2;
	logic [MOD_W-1:0] nxt;

	always_comb begin
		t  = {2'b00, acc_q, 1'b0} + (b_q[OPD_W-1] ? {3'b000, a_q} : '0);
		d1 = t - {3'b000, m};
		d2 = t - {2'b00, m, 1'b0};
		if (!d2[MOD_W+2]) begin
			nxt = d2[MOD_W-1:0];
		end else if (!d1[MOD_W+2]) begin
			nxt = d1[MOD_W-1:0];
		end else begin
			nxt = t[MOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == MM_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MM_CNT_W'(OPD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MM_CNT_W'(1);
				if (cnt_q == MM_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= nxt;
			b_q   <= {b_q[OPD_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

FILE: tb/modular_exponentiation_core_tb.sv
module modular_exponentiation_core_tb;
	import mexp_pkg::*;

	localparam int EXP_BITS = 32;
	localparam logic OP_POW = 1'b0;
	localparam logic OP_INV = 1'b1;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 148;
	localparam int HOLD_CYCLES = 3000;
	localparam int TAIL_CYCLES = 1200;
	localparam int STALL_LIMIT = 20000;
	localparam int NPLAN = 31;

	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	// For ROW_CFG rows the base field carries the modulus.
	typedef struct packed {
		row_kind_t        kind;
		logic             op;
		logic [OPD_W-1:0] base;
		logic [OPD_W-1:0] expo;
		logic             pinned;
		logic [MOD_W-1:0] want;
	} row_t;

	row_t plan [NPLAN] = '{
		'{ROW_CMD, OP_POW, 32'h0, 32'h0, 1'b1, 31'd1},
		'{ROW_CMD, OP_POW, 32'hFFFFFFFF, 32'h0, 1'b1, 31'd1},
		'{ROW_CMD, OP_POW, 32'd2, 32'd10, 1'b1, 31'd1024},
		'{ROW_CMD, OP_POW, 32'h0, 32'd5, 1'b1, 31'd0},
		'{ROW_CMD, OP_POW, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 31'd0},
		'{ROW_CMD, OP_POW, 32'd1000000007, 32'd3, 1'b1, 31'd0},
		'{ROW_CMD, OP_POW, 32'd7, 32'd1, 1'b1, 31'd7},
		'{ROW_CMD, OP_INV, 32'h0, 32'h0, 1'b1, 31'd0},
		'{ROW_CMD, OP_INV, 32'd1000000007, 32'hFFFFFFFF, 1'b1, 31'd0},
		'{ROW_CMD, OP_INV, 32'd1, 32'h0, 1'b1, 31'd1},
		'{ROW_CMD, OP_INV, 32'd2, 32'h0, 1'b1, 31'd500000004},
		'{ROW_CMD, OP_INV, 32'hFFFFFFFF, 32'h0, 1'b0, 31'd0},
		'{ROW_CFG, OP_POW, 32'h7FFFFFFF, 32'h0, 1'b0, 31'd0},
		'{ROW_CMD, OP_POW, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 31'd0},
		'{ROW_CMD, OP_INV, 32'h7FFFFFFE, 32'h0, 1'b1, 31'h7FFFFFFE},
		'{ROW_CMD, OP_INV, 32'd12345, 32'hAAAAAAAA, 1'b0, 31'd0},
		'{ROW_CMD, OP_POW, 32'h7FFFFFFE, 32'd2, 1'b1, 31'd1},
		'{ROW_CFG, OP_POW, 32'd2, 32'h0, 1'b0, 31'd0},
		'{ROW_CMD, OP_INV, 32'd3, 32'h0, 1'b1, 31'd1},
		'{ROW_CMD, OP_INV, 32'd4, 32'h0, 1'b1, 31'd0},
		'{ROW_CMD, OP_POW, 32'd5, 32'hFFFFFFFF, 1'b1, 31'd1},
		'{ROW_CMD, OP_POW, 32'd4, 32'h0, 1'b1, 31'd1},
		'{ROW_CFG, OP_POW, 32'd1, 32'h0, 1'b0, 31'd0},
		'{ROW_CMD, OP_POW, 32'd5, 32'd3, 1'b1, 31'd0},
		'{ROW_CMD, OP_INV, 32'd5, 32'h0, 1'b1, 31'd0},
		'{ROW_CFG, OP_POW, 32'd0, 32'h0, 1'b0, 31'd0},
		'{ROW_CMD, OP_POW, 32'h0, 32'h0, 1'b1, 31'd0},
		'{ROW_CMD, OP_INV, 32'hFFFFFFFF, 32'h0, 1'b1, 31'd0},
		'{ROW_CFG, OP_POW, 32'd15, 32'h0, 1'b0, 31'd0},
		'{ROW_CMD, OP_INV, 32'd2, 32'h0, 1'b0, 31'd0},
		'{ROW_CMD, OP_POW, 32'd14, 32'd5, 1'b0, 31'd0}
	};

	logic clk;
	logic arst_n;

	mexp_cfg_if cfg_if ();
	mexp_cmd_if cmd_if ();
	mexp_rsp_if rsp_if ();

	modular_exponentiation_core #(.EXP_BITS(EXP_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	logic [MOD_W-1:0] modulus_now = MOD_RESET;
	logic [MOD_W-1:0] results_due [$];
	logic [MOD_W-1:0] phase_mod [PHASES];
	logic             cmd_pinned;
	logic [MOD_W-1:0] cmd_want;
	logic             calm = 1'b0;
	logic             hold_off = 1'b0;
	int               fail_cnt = 0;

	function automatic logic [MOD_W-1:0] power_mod(input logic o, input logic [OPD_W-1:0] b,
			input logic [OPD_W-1:0] e, input logic [MOD_W-1:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] mm;
		logic [63:0] ex;
		if (m < 2)
			return '0;
		mm = 64'(m);
		sq = 64'(b) % mm;
		if (o == OP_INV) begin
			if (sq == 0)
				return '0;
			ex = mm - 2;
		end else begin
			ex = 64'(e);
		end
		ex &= (64'd1 << EXP_BITS) - 1;
		acc = 64'd1;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (ex[i])
				acc = (acc * sq) % mm;
			sq = (sq * sq) % mm;
		end
		return MOD_W'(acc % mm);
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	task automatic flag(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%s", msg);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : monitor
		logic [MOD_W-1:0] want;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				modulus_now = cfg_if.modulus;
			if (rsp_if.valid && rsp_if.ready) begin
				if (results_due.size() == 0) begin
					flag($sformatf("unexpected result %0d", rsp_if.result));
				end else begin
					want = results_due.pop_front();
					if (rsp_if.result !== want)
						flag($sformatf("result mismatch: expected %0d, got %0d",
							want, rsp_if.result));
				end
			end
			if (cmd_if.valid && cmd_if.ready)
				results_due.push_back(cmd_pinned ? cmd_want :
					power_mod(cmd_if.op, cmd_if.base, cmd_if.exponent, modulus_now));
		end
	end

	initial begin : watchdog
		int idle_cyc;
		idle_cyc = 0;
		while (idle_cyc < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				idle_cyc = 0;
			else
				idle_cyc++;
		end
		$display("modular_exponentiation_core_tb: errors");
		$finish;
	end

	initial begin : rsp_side
		int n;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			n = idle_len();
			if (n > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
		end
	end

	task automatic send_cmd(input logic o, input logic [OPD_W-1:0] b,
			input logic [OPD_W-1:0] e, input logic pin, input logic [MOD_W-1:0] want);
		int g;
		cmd_if.op <= o;
		cmd_if.base <= b;
		cmd_if.exponent <= e;
		cmd_pinned <= pin;
		cmd_want <= want;
		cmd_if.valid <= 1'b1;
		do @(posedge clk); while (!cmd_if.ready);
		@(negedge clk);
		g = idle_len();
		if (g > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		cmd_if.valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_modulus(input logic [MOD_W-1:0] m);
		cfg_if.modulus <= m;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic             o;
		logic [OPD_W-1:0] b;
		logic [OPD_W-1:0] e;
		logic [MOD_W-1:0] m;
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.modulus = '0;
		cmd_if.valid = 1'b0;
		cmd_if.op = OP_POW;
		cmd_if.base = '0;
		cmd_if.exponent = '0;
		cmd_pinned = 1'b0;
		cmd_want = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NPLAN; i++) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				write_modulus(MOD_W'(plan[i].base));
			end else begin
				send_cmd(plan[i].op, plan[i].base, plan[i].expo, plan[i].pinned, plan[i].want);
			end
		end

		phase_mod = '{31'h7FFFFFFF, 31'd998244353, 31'd2, 31'd3, 31'd65537,
			MOD_W'($urandom_range(2, 32'h7FFFFFFF)), MOD_W'($urandom_range(2, 1000)),
			31'd1000000007, MOD_W'($urandom_range(2, 32'h7FFFFFFF))};

		for (int k = 0; k < PHASES; k++) begin
			drain();
			m = phase_mod[k];
			write_modulus(m);
			calm = (k == 4);
			if (k == 1)
				hold_off = 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				o = $urandom_range(0, 1);
				case ($urandom_range(0, 9))
					0: b = '0;
					1: b = OPD_W'(m) * $urandom_range(0, 32'hFFFFFFFF / OPD_W'(m));
					2: b = 32'hFFFFFFFF - $urandom_range(0, 3);
					3: b = $urandom_range(0, 20);
					default: b = $urandom;
				endcase
				case ($urandom_range(0, 9))
					0: e = '0;
					1: e = 32'hFFFFFFFF;
					2: e = $urandom_range(0, 16);
					3: e = 32'd1 << $urandom_range(0, 31);
					default: e = $urandom;
				endcase
				send_cmd(o, b, e, 1'b0, '0);
			end
		end

		calm = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (results_due.size() != 0)
			flag($sformatf("%0d results never arrived", results_due.size()));
		if (fail_cnt == 0)
			$display("modular_exponentiation_core_tb: clean");
		else
			$display("modular_exponentiation_core_tb: errors");
		$finish;
	end

endmodule

FILE: files.f
sv/mexp_pkg.sv
sv/mexp_if.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation_core.sv
tb/modular_exponentiation_core_tb.sv
